// ----- hw/rtl/cts_pkg.sv -----
// Shared types, constants and helper functions for the clock time/date setter.
package cts_pkg;

  // Input word after unpacking from the stream.
  typedef struct packed {
    logic       op;
    logic       btn_mode;
    logic       btn_inc;
    logic       btn_dec;
    logic       btn_select;
    logic       btn_alarm_toggle;
    logic [4:0] rtc_hours;
    logic [5:0] rtc_minutes;
    logic [5:0] rtc_seconds;
    logic [3:0] rtc_month;
    logic [4:0] rtc_day;
    logic [6:0] rtc_year;
  } item_t;

  // Result word, one per input word.
  typedef struct packed {
    logic       alarm_enabled;
    logic [5:0] alarm_seconds;
    logic [5:0] alarm_minutes;
    logic [4:0] alarm_hours;
    logic [6:0] set_year;
    logic [4:0] set_day;
    logic [3:0] set_month;
    logic [5:0] set_seconds;
    logic [5:0] set_minutes;
    logic [4:0] set_hours;
    logic [2:0] sel_field;
    logic [1:0] cur_mode;
  } res_t;

  // Handshake between the input register and the step stage.
  typedef struct packed {
    logic valid;
    logic take;
  } hs_t;

  localparam int InDataW  = 40;
  localparam int OutDataW = 56;

  typedef enum logic [2:0] {
    MODE_DISPLAY = 3'b001,
    MODE_SET_CLK = 3'b010,
    MODE_SET_ALM = 3'b100
  } mode_t;

  localparam logic [1:0] CODE_DISPLAY = 2'd0;
  localparam logic [1:0] CODE_SET_CLK = 2'd1;
  localparam logic [1:0] CODE_SET_ALM = 2'd2;

  localparam logic [2:0] FLD_HOUR   = 3'd0;
  localparam logic [2:0] FLD_MINUTE = 3'd1;
  localparam logic [2:0] FLD_SECOND = 3'd2;
  localparam logic [2:0] FLD_MONTH  = 3'd3;
  localparam logic [2:0] FLD_DAY    = 3'd4;
  localparam logic [2:0] FLD_YEAR   = 3'd5;

  localparam logic [6:0] HOURS_MAX = 7'd23;
  localparam logic [6:0] MINSEC_MAX = 7'd59;
  localparam logic [6:0] MONTH_MAX = 7'd12;
  localparam logic [6:0] DAY_MAX   = 7'd31;
  localparam logic [6:0] YEAR_MAX  = 7'd99;
  localparam logic [6:0] VAL_ZERO  = 7'd0;
  localparam logic [6:0] VAL_ONE   = 7'd1;

  function automatic logic [1:0] mode_code(input mode_t m);
    logic [1:0] c;
    case (m)
      MODE_DISPLAY: c = CODE_DISPLAY;
      MODE_SET_CLK: c = CODE_SET_CLK;
      MODE_SET_ALM: c = CODE_SET_ALM;
      default:      c = CODE_DISPLAY;
    endcase
    return c;
  endfunction

  // Saturating step; increment wins over decrement.
  function automatic logic [6:0] adjust_val(input logic [6:0] v, input logic [6:0] lo,
                                            input logic [6:0] hi, input logic inc,
                                            input logic dec);
    logic [6:0] r;
    r = v;
    if (inc) begin
      if (v < hi) r = v + 7'd1;
    end else if (dec) begin
      if (v > lo) r = v - 7'd1;
    end
    return r;
  endfunction

  function automatic logic [6:0] clamp_val(input logic [6:0] v, input logic [6:0] lo,
                                           input logic [6:0] hi);
    logic [6:0] r;
    r = v;
    if (v < lo) r = lo;
    else if (v > hi) r = hi;
    return r;
  endfunction

endpackage

// ----- hw/rtl/cts_in_reg.sv -----
// Input register stage: unpacks and holds one input word.
module cts_in_reg
  import cts_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [InDataW-1:0]  in_tdata,
  input  logic                in_tuser,
  input  logic                take,
  output hs_t                 hs,
  output item_t               item
);

  logic  valid_r, valid_nxt;
  item_t item_r;
  logic  load;

  assign in_tready = !valid_r || take;
  assign load      = in_tvalid && in_tready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) valid_nxt = 1'b1;
    else if (take) valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r.op               <= in_tuser;
      item_r.btn_mode         <= in_tdata[0];
      item_r.btn_inc          <= in_tdata[1];
      item_r.btn_dec          <= in_tdata[2];
      item_r.btn_select       <= in_tdata[3];
      item_r.btn_alarm_toggle <= in_tdata[4];
      item_r.rtc_hours        <= in_tdata[9:5];
      item_r.rtc_minutes      <= in_tdata[15:10];
      item_r.rtc_seconds      <= in_tdata[21:16];
      item_r.rtc_month        <= in_tdata[25:22];
      item_r.rtc_day          <= in_tdata[30:26];
      item_r.rtc_year         <= in_tdata[37:31];
    end
  end

  assign hs.valid = valid_r;
  assign hs.take  = take;
  assign item     = item_r;

endmodule

// ----- hw/rtl/cts_step.sv -----
// Setter state registers, next-state logic and result valid flag.
module cts_step
  import cts_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  hs_t   hs,
  input  item_t item,
  output logic  take,
  output logic  out_valid,
  input  logic  out_ready,
  output res_t  res
);

  mode_t      mode_r, mode_nxt;
  logic [2:0] field_r, field_nxt;
  logic [4:0] hours_r, hours_nxt;
  logic [5:0] minutes_r, minutes_nxt;
  logic [5:0] seconds_r, seconds_nxt;
  logic [3:0] month_r, month_nxt;
  logic [4:0] day_r, day_nxt;
  logic [6:0] year_r, year_nxt;
  logic [4:0] ahours_r, ahours_nxt;
  logic [5:0] aminutes_r, aminutes_nxt;
  logic [5:0] aseconds_r, aseconds_nxt;
  logic       alarm_on_r, alarm_on_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       inc, dec;
  logic [2:0] next6, next3;

  // State doubles as the result register: it only moves once the last word is taken.
  assign take = hs.valid && (!out_valid_r || out_ready);
  assign inc  = item.btn_inc;
  assign dec  = item.btn_dec;

  always_comb begin
    case (field_r)
      3'd0:    begin next6 = 3'd1; next3 = 3'd1; end
      3'd1:    begin next6 = 3'd2; next3 = 3'd2; end
      3'd2:    begin next6 = 3'd3; next3 = 3'd0; end
      3'd3:    begin next6 = 3'd4; next3 = 3'd1; end
      3'd4:    begin next6 = 3'd5; next3 = 3'd2; end
      3'd5:    begin next6 = 3'd0; next3 = 3'd0; end
      3'd6:    begin next6 = 3'd1; next3 = 3'd1; end
      default: begin next6 = 3'd2; next3 = 3'd2; end
    endcase
  end

  always_comb begin
    mode_nxt     = mode_r;
    field_nxt    = field_r;
    hours_nxt    = hours_r;
    minutes_nxt  = minutes_r;
    seconds_nxt  = seconds_r;
    month_nxt    = month_r;
    day_nxt      = day_r;
    year_nxt     = year_r;
    ahours_nxt   = ahours_r;
    aminutes_nxt = aminutes_r;
    aseconds_nxt = aseconds_r;
    alarm_on_nxt = alarm_on_r;
    if (take) begin
      if (item.op) begin
        if (mode_r != MODE_SET_CLK && mode_r != MODE_SET_ALM) begin
          hours_nxt   = 5'(clamp_val({2'b0, item.rtc_hours}, VAL_ZERO, HOURS_MAX));
          minutes_nxt = 6'(clamp_val({1'b0, item.rtc_minutes}, VAL_ZERO, MINSEC_MAX));
          seconds_nxt = 6'(clamp_val({1'b0, item.rtc_seconds}, VAL_ZERO, MINSEC_MAX));
          month_nxt   = 4'(clamp_val({3'b0, item.rtc_month}, VAL_ONE, MONTH_MAX));
          day_nxt     = 5'(clamp_val({2'b0, item.rtc_day}, VAL_ONE, DAY_MAX));
          year_nxt    = clamp_val(item.rtc_year, VAL_ZERO, YEAR_MAX);
        end
      end else begin
        if (item.btn_mode) begin
          field_nxt = FLD_HOUR;
          case (mode_r)
            MODE_DISPLAY: mode_nxt = MODE_SET_CLK;
            MODE_SET_CLK: mode_nxt = MODE_SET_ALM;
            MODE_SET_ALM: mode_nxt = MODE_DISPLAY;
            default:      mode_nxt = MODE_SET_CLK;
          endcase
        end else begin
          case (mode_r)
            MODE_SET_CLK: begin
              case (field_r)
                FLD_HOUR:   hours_nxt = 5'(adjust_val({2'b0, hours_r}, VAL_ZERO,
                                                      HOURS_MAX, inc, dec));
                FLD_MINUTE: minutes_nxt = 6'(adjust_val({1'b0, minutes_r}, VAL_ZERO,
                                                        MINSEC_MAX, inc, dec));
                FLD_SECOND: seconds_nxt = 6'(adjust_val({1'b0, seconds_r}, VAL_ZERO,
                                                        MINSEC_MAX, inc, dec));
                FLD_MONTH:  month_nxt = 4'(adjust_val({3'b0, month_r}, VAL_ONE,
                                                      MONTH_MAX, inc, dec));
                FLD_DAY:    day_nxt = 5'(adjust_val({2'b0, day_r}, VAL_ONE,
                                                    DAY_MAX, inc, dec));
                FLD_YEAR:   year_nxt = adjust_val(year_r, VAL_ZERO, YEAR_MAX, inc, dec);
                default: ;
              endcase
              if (item.btn_select) field_nxt = next6;
            end
            MODE_SET_ALM: begin
              case (field_r)
                FLD_HOUR:   ahours_nxt = 5'(adjust_val({2'b0, ahours_r}, VAL_ZERO,
                                                       HOURS_MAX, inc, dec));
                FLD_MINUTE: aminutes_nxt = 6'(adjust_val({1'b0, aminutes_r}, VAL_ZERO,
                                                         MINSEC_MAX, inc, dec));
                FLD_SECOND: aseconds_nxt = 6'(adjust_val({1'b0, aseconds_r}, VAL_ZERO,
                                                         MINSEC_MAX, inc, dec));
                default: ;
              endcase
              if (item.btn_select) field_nxt = next3;
            end
            default: ;
          endcase
        end
        if (item.btn_alarm_toggle) alarm_on_nxt = !alarm_on_r;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (take) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_DISPLAY;
      field_r     <= FLD_HOUR;
      hours_r     <= '0;
      minutes_r   <= '0;
      seconds_r   <= '0;
      month_r     <= 4'd1;
      day_r       <= 5'd1;
      year_r      <= '0;
      ahours_r    <= '0;
      aminutes_r  <= '0;
      aseconds_r  <= '0;
      alarm_on_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      mode_r      <= mode_nxt;
      field_r     <= field_nxt;
      hours_r     <= hours_nxt;
      minutes_r   <= minutes_nxt;
      seconds_r   <= seconds_nxt;
      month_r     <= month_nxt;
      day_r       <= day_nxt;
      year_r      <= year_nxt;
      ahours_r    <= ahours_nxt;
      aminutes_r  <= aminutes_nxt;
      aseconds_r  <= aseconds_nxt;
      alarm_on_r  <= alarm_on_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign res.cur_mode      = mode_code(mode_r);
  assign res.sel_field     = field_r;
  assign res.set_hours     = hours_r;
  assign res.set_minutes   = minutes_r;
  assign res.set_seconds   = seconds_r;
  assign res.set_month     = month_r;
  assign res.set_day       = day_r;
  assign res.set_year      = year_r;
  assign res.alarm_hours   = ahours_r;
  assign res.alarm_minutes = aminutes_r;
  assign res.alarm_seconds = aseconds_r;
  assign res.alarm_enabled = alarm_on_r;

endmodule

// ----- hw/rtl/clock_time_date_setter.sv -----
// Top level of the clock time/date/alarm setter.
// Takes one button-poll or refresh word per cycle unless the output stalls, and returns one
// result word per input word: the mode, field selector, set time/date, alarm time and alarm
// enable after that word. Sustained rate is one word per clock while out_tready is high; a word
// passes the input register, then the setter state register, which is also the result
// register. A word sits in the input register until the previous result has been taken, so a
// stalled output holds one result and one pending input before in_tready drops.
module clock_time_date_setter
  import cts_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  // btn_mode, btn_inc, btn_dec, btn_select, btn_alarm_toggle, rtc_hours, rtc_minutes,
  // rtc_seconds, rtc_month, rtc_day, rtc_year, 2 zero bits
  input  logic [InDataW-1:0]  in_tdata,
  // op
  input  logic                in_tuser,
  output logic                out_tvalid,
  input  logic                out_tready,
  // cur_mode, sel_field, set_hours, set_minutes, set_seconds, set_month, set_day,
  // set_year, alarm_hours, alarm_minutes, alarm_seconds, alarm_enabled
  output logic [OutDataW-1:0] out_tdata
);

  hs_t   hs;
  item_t item;
  logic  take;
  res_t  res;

  cts_in_reg u_in_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .take      (take),
    .hs        (hs),
    .item      (item)
  );

  cts_step u_step (
    .clk       (clk),
    .rst_n     (rst_n),
    .hs        (hs),
    .item      (item),
    .take      (take),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .res       (res)
  );

  assign out_tdata = res;

endmodule

// ----- hw/rtl/cts_checker.sv -----
// Port-level checks for the clock time/date setter, bound to the top level.
module cts_checker
  import cts_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                out_tvalid,
  input logic                out_tready,
  input logic [OutDataW-1:0] out_tdata
);

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_mode_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[1:0] != 2'd3)
    else $error("illegal mode code");

  a_field_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[4:2] != 3'd6 && out_tdata[4:2] != 3'd7)
    else $error("field selector out of range");

  a_alarm_field: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1:0] == CODE_SET_ALM |-> out_tdata[4:2] != 3'd3 &&
      out_tdata[4:2] != 3'd4 && out_tdata[4:2] != 3'd5)
    else $error("alarm field selector out of range");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result word changed");

endmodule

bind clock_time_date_setter cts_checker u_cts_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
